// ===== hw/rtl/pfrc_pkg.sv =====
// Package for prime_factor_range_count: shared constants.
// No dependencies.
package pfrc_pkg;
	localparam int unsigned FieldWidth = 16;
	localparam int unsigned SumWidth   = 32;
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
endpackage

// ===== hw/rtl/pfrc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pfrc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/prime_factor_range_count.sv =====
// prime_factor_range_count: distinct prime factor counts with range-sum queries.
// After reset a clearing pass over the table, then a sieve over each index and each
// composite marked, run before s_tready rises.
// A load walks its prime factor steps, each a restoring division of the value;
// a query walks each entry in the range (one entry for an empty range), so the walk sets
// throughput. A result waits in the output register while the next transaction enters.
// Depends on pfrc_pkg and pfrc_ram.
module prime_factor_range_count
	import pfrc_pkg::*;
#(
	parameter int unsigned MAX_VALUE   = 65536,
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // value[15:0], range_low[31:16], range_high[47:32]
	input  logic        s_tuser,  // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // range_sum[31:0]
);
	localparam int unsigned TableSize = (MAX_VALUE < 65536) ? MAX_VALUE : 65536;
	localparam int unsigned AW = $clog2(TableSize);
	localparam logic [AW:0] TopIdx = (AW+1)'(TableSize - 1);
	localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

	typedef enum logic [14:0] {
		ST_CLEAR  = 15'd1,
		ST_SI     = 15'd2,
		ST_SI_W   = 15'd4,
		ST_SI_CHK = 15'd8,
		ST_SJ     = 15'd16,
		ST_SJ_W   = 15'd32,
		ST_SJ_CHK = 15'd64,
		ST_IDLE   = 15'd128,
		ST_L_RD   = 15'd256,
		ST_L_W    = 15'd512,
		ST_L_CNT  = 15'd1024,
		ST_L_DIV  = 15'd2048,
		ST_Q_RD   = 15'd4096,
		ST_Q_W    = 15'd8192,
		ST_Q_ADD  = 15'd16384
	} state_t;

	state_t state_q;
	logic [AW:0] i_q, j_q, hi_q;
	logic [16:0] v_q, p_q, last_q, quo_q, rem_q;
	logic [4:0] bit_q;
	logic [SumWidth:0] sum_q;
	logic [31:0] out_q;
	logic out_v_q;
	logic zero_q;

	logic ft_we, pc_we;
	logic [AW-1:0] ft_addr, pc_addr;
	logic [FieldWidth-1:0] ft_wd, ft_rd;
	logic [COUNT_WIDTH-1:0] pc_wd, pc_rd;

	pfrc_ram #(.WIDTH(FieldWidth), .DEPTH(TableSize)) u_ft (
		.clk(clk), .we(ft_we), .addr(ft_addr), .wdata(ft_wd), .rdata(ft_rd));
	pfrc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TableSize)) u_pc (
		.clk(clk), .we(pc_we), .addr(pc_addr), .wdata(pc_wd), .rdata(pc_rd));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	logic [16:0] rem_sh;
	assign rem_sh = {rem_q[15:0], quo_q[16]};

	logic [SumWidth:0] sum_next;
	logic sum_sat;
	assign sum_next = sum_q + (SumWidth+1)'(pc_rd);
	assign sum_sat  = (sum_next >= (SumWidth+1)'(32'hFFFF_FFFF));

	// memory address and write control per state
	always_comb begin
		ft_we = 1'b0; pc_we = 1'b0;
		ft_wd = '0; pc_wd = '0;
		ft_addr = i_q[AW-1:0]; pc_addr = i_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ft_we = 1'b1; pc_we = 1'b1;
			end
			ST_SI_CHK: begin
				ft_we = (ft_rd == '0); ft_wd = FieldWidth'(i_q);
			end
			ST_SJ, ST_SJ_W: ft_addr = j_q[AW-1:0];
			ST_SJ_CHK: begin
				ft_addr = j_q[AW-1:0];
				ft_we = (ft_rd == '0); ft_wd = FieldWidth'(i_q);
			end
			ST_L_RD, ST_L_W: ft_addr = v_q[AW-1:0];
			ST_L_CNT: pc_addr = p_q[AW-1:0];
			ST_L_DIV: begin
				pc_addr = p_q[AW-1:0];
				pc_we = (bit_q == 5'd16) && (p_q != last_q) && (pc_rd != CntMax);
				pc_wd = pc_rd + 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer: clear and sieve after reset, then load and query walks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			i_q <= '0; j_q <= '0; hi_q <= '0;
			v_q <= '0; p_q <= '0; last_q <= '0; quo_q <= '0; rem_q <= '0;
			bit_q <= '0; sum_q <= '0; out_q <= '0; out_v_q <= 1'b0; zero_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (i_q == TopIdx) begin
						i_q <= (AW+1)'(2);
						state_q <= (TableSize > 2) ? ST_SI : ST_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_SI: state_q <= ST_SI_W;
				ST_SI_W: state_q <= ST_SI_CHK;
				ST_SI_CHK: begin
					if (ft_rd == '0 && ((2*AW+2)'(i_q) * (2*AW+2)'(i_q)) <= (2*AW+2)'(TopIdx)) begin
						j_q <= (AW+1)'(i_q * i_q);
						state_q <= ST_SJ;
					end else if (i_q == TopIdx) begin
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_SI;
					end
				end
				ST_SJ: state_q <= ST_SJ_W;
				ST_SJ_W: state_q <= ST_SJ_CHK;
				ST_SJ_CHK: begin
					if ((AW+2)'(j_q) + (AW+2)'(i_q) > (AW+2)'(TopIdx)) begin
						if (i_q == TopIdx) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_SI;
						end
					end else begin
						j_q <= j_q + i_q;
						state_q <= ST_SJ;
					end
				end
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						if (s_tuser == REQ_LOAD) begin
							v_q <= {1'b0, s_tdata[15:0]};
							last_q <= '0;
							if (s_tdata[15:0] > 16'd1 && 17'(s_tdata[15:0]) <= 17'(TopIdx))
								state_q <= ST_L_RD;
						end else begin
							sum_q <= '0;
							i_q <= (AW+1)'(s_tdata[31:16]);
							hi_q <= (17'(s_tdata[47:32]) > 17'(TopIdx)) ? TopIdx
								: (AW+1)'(s_tdata[47:32]);
							// empty range still walks one entry, then returns zero
							zero_q <= (17'(s_tdata[31:16]) > 17'(TopIdx)) ||
								(s_tdata[31:16] > s_tdata[47:32]);
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_L_RD: state_q <= ST_L_W;
				ST_L_W: begin
					p_q <= {1'b0, ft_rd};
					quo_q <= v_q; rem_q <= '0; bit_q <= '0;
					state_q <= (ft_rd < 16'd2) ? ST_IDLE : ST_L_CNT;
				end
				ST_L_CNT: state_q <= ST_L_DIV;
				// restoring division, one quotient bit per cycle
				ST_L_DIV: begin
					if (bit_q == 5'd17) begin
						last_q <= p_q;
						v_q <= quo_q;
						state_q <= (quo_q > 17'd1) ? ST_L_RD : ST_IDLE;
					end else begin
						if (rem_sh >= p_q) begin
							rem_q <= rem_sh - p_q;
							quo_q <= {quo_q[15:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[15:0], 1'b0};
						end
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_Q_RD: state_q <= ST_Q_W;
				ST_Q_W: state_q <= ST_Q_ADD;
				// accumulate; hold the final sum until the output register is free
				ST_Q_ADD: begin
					if (zero_q || sum_sat || i_q == hi_q) begin
						if (!out_v_q || m_tready) begin
							out_v_q <= 1'b1; state_q <= ST_IDLE;
							priority if (zero_q) begin
								out_q <= '0;
							end else if (sum_sat) begin
								out_q <= '1;
							end else begin
								out_q <= 32'(sum_next);
							end
						end
					end else begin
						sum_q <= sum_next;
						i_q <= i_q + 1'b1;
						state_q <= ST_Q_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
